@@ design/civs_pkg.sv @@
package civs_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_W = 31;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_TIME     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INV_FRAME_TIME = 2'd1;

  localparam logic [CFG_W-1:0] FRAME_TIME_RST     = 31'd1092;
  localparam logic [CFG_W-1:0] INV_FRAME_TIME_RST = 31'd3932160;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = -32'sh7fffffff - 32'sd1;

  typedef struct packed {
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic signed [31:0] penetration_depth;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] vel_a_z;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
    logic signed [31:0] vel_b_z;
    logic [30:0]        inv_mass_a;
    logic [30:0]        inv_mass_b;
  } contact_t;

  typedef struct packed {
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_z;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_z;
  } result_t;

  // Per-contact data carried alongside the arithmetic
  typedef struct packed {
    logic signed [31:0] n_x;
    logic signed [31:0] n_z;
    logic signed [31:0] va_x;
    logic signed [31:0] va_z;
    logic signed [31:0] vb_x;
    logic signed [31:0] vb_z;
    logic [30:0]        ima;
    logic [30:0]        imb;
    logic               no_mass;
  } side_t;

  function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
    logic signed [31:0] r;
    if (x > 68'(S32_MAX)) begin
      r = S32_MAX;
    end else if (x < 68'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Q x Q product, floored and saturated
  function automatic logic signed [31:0] qmul(input logic signed [32:0] a,
                                              input logic signed [32:0] b,
                                              input int frac);
    logic signed [65:0] p;
    logic signed [65:0] s;
    p = a * b;
    s = p >>> frac;
    return sat32({{2{s[65]}}, s});
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [31:0] x);
    return {x[31], x};
  endfunction

endpackage

@@ design/civs_in_if.sv @@
interface civs_in_if;
  import civs_pkg::*;
  logic     valid;
  logic     ready;
  contact_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/civs_out_if.sv @@
interface civs_out_if;
  import civs_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ design/civs_div.sv @@
module civs_div #(
  parameter int FRAC_BITS = civs_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [31:0]          den,
  output logic [2*FRAC_BITS:0] quo
);
  import civs_pkg::*;

  localparam int QW = 2 * FRAC_BITS + 1;

  logic [31:0]   rem   [QW];
  logic [QW-1:0] quo_r [QW];
  logic [31:0]   den_r [QW];

  // One quotient bit per stage; the dividend is a single one at its top bit
  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [31:0]   rem_in;
    logic [QW-1:0] q_in;
    logic [31:0]   d_in;
    logic [32:0]   t;
    logic          ge;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign q_in   = '0;
      assign d_in   = den;
      assign t      = {rem_in, 1'b1};
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign q_in   = quo_r[i-1];
      assign d_in   = den_r[i-1];
      assign t      = {rem_in, 1'b0};
    end

    assign ge = (t >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]   <= ge ? 32'(t - {1'b0, d_in}) : t[31:0];
        quo_r[i] <= {q_in[QW-2:0], ge};
        den_r[i] <= d_in;
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

@@ design/contact_impulse_velocity_solver.sv @@
// Contact impulse velocity solver.
// Contacts arrive on the contact channel (valid/ready) as one word each:
// normal, penetration depth, both body velocities and inverse masses.
// Each word yields exactly one result word on the result channel with the
// updated x and z velocities of both bodies, in signed fixed point.
// frame_time and inverse_frame_time are written through cfg_we/cfg_index/
// cfg_data; the user must do so only while no contact is in flight, which
// the block does not enforce. Unknown indexes are ignored. Throughput:
// one contact per cycle unless results stall. The effective-mass divider
// resolves one quotient bit per stage, with two stages ahead and six behind.
// Reset (rst, synchronous) empties the pipeline and restores the default
// frame time registers.
// The whole pipeline holds while the result word waits: contact.ready is
// low exactly when a result is valid and not taken, so no word is lost or
// repeated under stalls on either side.
module contact_impulse_velocity_solver #(
  parameter int FRAC_BITS = civs_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [civs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [civs_pkg::CFG_W-1:0]     cfg_data,
  civs_in_if.sink                        contact,
  civs_out_if.source                     result
);
  import civs_pkg::*;

  localparam int QW = 2 * FRAC_BITS + 1;
  localparam logic signed [32:0] BIAS_Q = 33'(((64'd1 << FRAC_BITS) * 2 + 5) / 10);

  logic [CFG_W-1:0] frame_time;
  logic [CFG_W-1:0] inverse_frame_time;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_time         <= FRAME_TIME_RST;
      inverse_frame_time <= INV_FRAME_TIME_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_TIME:     frame_time         <= cfg_data;
        REG_INV_FRAME_TIME: inverse_frame_time <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  assign en = !result.valid || result.ready;
  assign contact.ready = en;

  // Stage 1: velocity differences, mass sum, first bias product
  logic               v1;
  logic signed [32:0] s1_diff [3];
  logic signed [31:0] s1_n    [3];
  logic [31:0]        s1_msum;
  logic signed [31:0] s1_bias;
  side_t              s1_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= contact.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_diff[0] <= sx33(contact.data.vel_b_x) - sx33(contact.data.vel_a_x);
      s1_diff[1] <= sx33(contact.data.vel_b_y) - sx33(contact.data.vel_a_y);
      s1_diff[2] <= sx33(contact.data.vel_b_z) - sx33(contact.data.vel_a_z);
      s1_n[0]    <= contact.data.normal_x;
      s1_n[1]    <= contact.data.normal_y;
      s1_n[2]    <= contact.data.normal_z;
      s1_msum    <= {1'b0, contact.data.inv_mass_a} + {1'b0, contact.data.inv_mass_b};
      s1_bias    <= qmul(sx33(contact.data.penetration_depth),
                         $signed({2'b00, inverse_frame_time}), FRAC_BITS);
      s1_side.n_x     <= contact.data.normal_x;
      s1_side.n_z     <= contact.data.normal_z;
      s1_side.va_x    <= contact.data.vel_a_x;
      s1_side.va_z    <= contact.data.vel_a_z;
      s1_side.vb_x    <= contact.data.vel_b_x;
      s1_side.vb_z    <= contact.data.vel_b_z;
      s1_side.ima     <= contact.data.inv_mass_a;
      s1_side.imb     <= contact.data.inv_mass_b;
      s1_side.no_mass <= (contact.data.inv_mass_a == '0) && (contact.data.inv_mass_b == '0);
    end
  end

  // Stage 2: normal-velocity products, bias scaled by the Baumgarte factor
  logic               v2;
  logic signed [65:0] s2_prod [3];
  logic [31:0]        s2_msum;
  logic signed [31:0] s2_bias;
  side_t              s2_side;
  logic signed [65:0] p [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p[i] = s1_diff[i] * sx33(s1_n[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s2_prod[i] <= p[i] >>> FRAC_BITS;
      end
      s2_msum <= s1_msum;
      s2_bias <= qmul(sx33(s1_bias), BIAS_Q, FRAC_BITS);
      s2_side <= s1_side;
    end
  end

  // Divider stages: effective mass, with the rest of the contact alongside
  logic [QW-1:0]      quo;
  logic               vd      [QW];
  side_t              d_side  [QW];
  logic signed [31:0] d_rel   [QW];
  logic signed [31:0] d_bias  [QW];
  logic signed [67:0] rel_sum;

  civs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .en  (en),
    .den (s2_msum),
    .quo (quo)
  );

  assign rel_sum = {{2{s2_prod[0][65]}}, s2_prod[0]} + {{2{s2_prod[1][65]}}, s2_prod[1]}
                 + {{2{s2_prod[2][65]}}, s2_prod[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < QW; i++) begin
        vd[i] <= 1'b0;
      end
    end else if (en) begin
      vd[0] <= v2;
      for (int i = 1; i < QW; i++) begin
        vd[i] <= vd[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_side[0] <= s2_side;
      d_rel[0]  <= sat32(rel_sum);
      d_bias[0] <= s2_bias;
      for (int i = 1; i < QW; i++) begin
        d_side[i] <= d_side[i-1];
        d_rel[i]  <= d_rel[i-1];
        d_bias[i] <= d_bias[i-1];
      end
    end
  end

  // E1: impulse terms
  logic [63:0]        quo_wide;
  logic signed [32:0] em;
  logic               ve1;
  logic signed [31:0] e1_mag;
  logic signed [31:0] e1_bias;
  side_t              e1_side;

  assign quo_wide = 64'(quo);
  assign em = (quo_wide > 64'h7fffffff) ? 33'sh07fffffff : $signed({1'b0, quo_wide[31:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      e1_mag  <= qmul(-sx33(d_rel[QW-1]), em, FRAC_BITS);
      e1_bias <= qmul(sx33(d_bias[QW-1]), em, FRAC_BITS);
      e1_side <= d_side[QW-1];
    end
  end

  // E2: total impulse
  logic               ve2;
  logic signed [31:0] e2_total;
  side_t              e2_side;

  always_ff @(posedge clk) begin
    if (en) begin
      e2_total <= sat32(68'(e1_mag) + 68'(e1_bias));
      e2_side  <= e1_side;
    end
  end

  // E3: impulse along x and z
  logic               ve3;
  logic signed [31:0] e3_imp_x;
  logic signed [31:0] e3_imp_z;
  side_t              e3_side;

  always_ff @(posedge clk) begin
    if (en) begin
      e3_imp_x <= qmul(sx33(e2_side.n_x), sx33(e2_total), FRAC_BITS);
      e3_imp_z <= qmul(sx33(e2_side.n_z), sx33(e2_total), FRAC_BITS);
      e3_side  <= e2_side;
    end
  end

  // E4: scale by frame time
  logic               ve4;
  logic signed [31:0] e4_acc_x;
  logic signed [31:0] e4_acc_z;
  side_t              e4_side;

  always_ff @(posedge clk) begin
    if (en) begin
      e4_acc_x <= qmul(sx33(e3_imp_x), $signed({2'b00, frame_time}), FRAC_BITS);
      e4_acc_z <= qmul(sx33(e3_imp_z), $signed({2'b00, frame_time}), FRAC_BITS);
      e4_side  <= e3_side;
    end
  end

  // E5: velocity changes per body
  logic               ve5;
  logic signed [31:0] e5_da_x;
  logic signed [31:0] e5_da_z;
  logic signed [31:0] e5_db_x;
  logic signed [31:0] e5_db_z;
  side_t              e5_side;

  always_ff @(posedge clk) begin
    if (en) begin
      e5_da_x <= qmul(sx33(e4_acc_x), $signed({2'b00, e4_side.ima}), FRAC_BITS);
      e5_da_z <= qmul(sx33(e4_acc_z), $signed({2'b00, e4_side.ima}), FRAC_BITS);
      e5_db_x <= qmul(sx33(e4_acc_x), $signed({2'b00, e4_side.imb}), FRAC_BITS);
      e5_db_z <= qmul(sx33(e4_acc_z), $signed({2'b00, e4_side.imb}), FRAC_BITS);
      e5_side <= e4_side;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ve1 <= 1'b0;
      ve2 <= 1'b0;
      ve3 <= 1'b0;
      ve4 <= 1'b0;
      ve5 <= 1'b0;
      result.valid <= 1'b0;
    end else if (en) begin
      ve1 <= vd[QW-1];
      ve2 <= ve1;
      ve3 <= ve2;
      ve4 <= ve3;
      ve5 <= ve4;
      result.valid <= ve5;
    end
  end

  // E6: output word; massless pairs pass velocities through
  always_ff @(posedge clk) begin
    if (en) begin
      if (e5_side.no_mass) begin
        result.data.new_vel_a_x <= e5_side.va_x;
        result.data.new_vel_a_z <= e5_side.va_z;
        result.data.new_vel_b_x <= e5_side.vb_x;
        result.data.new_vel_b_z <= e5_side.vb_z;
      end else begin
        result.data.new_vel_a_x <= sat32(68'(e5_side.va_x) - 68'(e5_da_x));
        result.data.new_vel_a_z <= sat32(68'(e5_side.va_z) - 68'(e5_da_z));
        result.data.new_vel_b_x <= sat32(68'(e5_side.vb_x) + 68'(e5_db_x));
        result.data.new_vel_b_z <= sat32(68'(e5_side.vb_z) + 68'(e5_db_z));
      end
    end
  end

  a_rst_empty : assert property (@(posedge clk) rst |=> !result.valid && !ve5 && !v1)
    else $error("pipeline not empty after reset");

  a_stall_only_on_hold : assert property (@(posedge clk) disable iff (rst)
    !contact.ready |-> result.valid && !result.ready)
    else $error("input stalled without a held result");

  a_hold_stage : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(ve5) && $stable(vd[QW-1]) && $stable(v2))
    else $error("pipeline moved during a stall");

  a_out_from_stage : assert property (@(posedge clk) disable iff (rst)
    en && !$past(rst) |=> result.valid == $past(ve5))
    else $error("result valid does not follow last stage");

endmodule

@@ test/civs_checker.sv @@
`timescale 1ns / 1ps

module civs_checker (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_we,
  input  logic [civs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [civs_pkg::CFG_W-1:0]     cfg_data,
  civs_in_if       contact_mon,
  civs_out_if      result_mon,
  input  logic     contact_rdy,
  input  logic     result_rdy,
  output int       fail_count,
  output int       pending,
  output int       results_seen
);
  import civs_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam longint BIAS_K = ((longint'(1) << FB) * 2 + 5) / 10;

  logic [30:0] frame_t;
  logic [30:0] inv_frame_t;
  result_t     velocity_q[$];

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // floor shift: >>> on a signed value already floors
  function automatic longint fx_mul(longint a, longint b);
    return clamp32((a * b) >>> FB);
  endfunction

  function automatic result_t solve_contact(contact_t c, logic [30:0] ft, logic [30:0] ift);
    result_t r;
    longint nx, ny, nz, ax, ay, az, bx, by, bz;
    longint ima, imb, sum, rel, em, mag, bias, total, imp, acc;
    longint ra, rb;
    longint unsigned q;
    nx = c.normal_x; ny = c.normal_y; nz = c.normal_z;
    ax = c.vel_a_x; ay = c.vel_a_y; az = c.vel_a_z;
    bx = c.vel_b_x; by = c.vel_b_y; bz = c.vel_b_z;
    ima = c.inv_mass_a; imb = c.inv_mass_b;
    r.new_vel_a_x = c.vel_a_x; r.new_vel_a_z = c.vel_a_z;
    r.new_vel_b_x = c.vel_b_x; r.new_vel_b_z = c.vel_b_z;
    if (ima + imb != 0) begin
      sum = (((bx - ax) * nx) >>> FB) + (((by - ay) * ny) >>> FB)
          + (((bz - az) * nz) >>> FB);
      rel = clamp32(sum);
      q = (64'd1 << (2 * FB)) / longint'(ima + imb);
      em = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
      mag = fx_mul(-rel, em);
      bias = fx_mul(c.penetration_depth, longint'(ift));
      bias = fx_mul(bias, BIAS_K);
      bias = fx_mul(bias, em);
      total = clamp32(mag + bias);
      imp = fx_mul(nx, total);
      acc = fx_mul(imp, longint'(ft));
      ra = clamp32(ax - fx_mul(acc, ima)); rb = clamp32(bx + fx_mul(acc, imb));
      r.new_vel_a_x = ra[31:0]; r.new_vel_b_x = rb[31:0];
      imp = fx_mul(nz, total);
      acc = fx_mul(imp, longint'(ft));
      ra = clamp32(az - fx_mul(acc, ima)); rb = clamp32(bz + fx_mul(acc, imb));
      r.new_vel_a_z = ra[31:0]; r.new_vel_b_z = rb[31:0];
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    int      errs;
    errs = 0;
    if (rst) begin
      frame_t <= FRAME_TIME_RST;
      inv_frame_t <= INV_FRAME_TIME_RST;
      fail_count <= 0;
      results_seen <= 0;
      pending <= 0;
      velocity_q.delete();
    end else begin
      if (cfg_we && cfg_index == REG_FRAME_TIME) frame_t <= cfg_data;
      if (cfg_we && cfg_index == REG_INV_FRAME_TIME) inv_frame_t <= cfg_data;
      if (contact_mon.valid && contact_rdy)
        velocity_q.insert(velocity_q.size(),
                          solve_contact(contact_mon.data, frame_t, inv_frame_t));
      if (result_mon.valid && result_rdy) begin
        results_seen <= results_seen + 1;
        if (velocity_q.size() == 0) begin
          $error("unexpected result word %h", result_mon.data);
          errs = errs + 1;
        end else begin
          want = velocity_q.pop_front();
          if (want.new_vel_a_x !== result_mon.data.new_vel_a_x) begin
            $error("new_vel_a_x exp %h got %h", want.new_vel_a_x, result_mon.data.new_vel_a_x);
            errs = errs + 1;
          end
          if (want.new_vel_a_z !== result_mon.data.new_vel_a_z) begin
            $error("new_vel_a_z exp %h got %h", want.new_vel_a_z, result_mon.data.new_vel_a_z);
            errs = errs + 1;
          end
          if (want.new_vel_b_x !== result_mon.data.new_vel_b_x) begin
            $error("new_vel_b_x exp %h got %h", want.new_vel_b_x, result_mon.data.new_vel_b_x);
            errs = errs + 1;
          end
          if (want.new_vel_b_z !== result_mon.data.new_vel_b_z) begin
            $error("new_vel_b_z exp %h got %h", want.new_vel_b_z, result_mon.data.new_vel_b_z);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= velocity_q.size();
    end
  end
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import civs_pkg::*;

  localparam int LATENCY = 2 * FRAC_BITS_DEF + 9;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_TIME;
  logic [CFG_W-1:0] cfg_data = '0;
  int fail_count, pending, results_seen;
  int cycles = 0;
  int sent = 0;
  bit calm = 0;

  civs_in_if  contact_ch();
  civs_out_if result_ch();

  always #6 clk = ~clk;

  contact_impulse_velocity_solver DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .contact(contact_ch.sink), .result(result_ch.source)
  );

  civs_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .contact_mon(contact_ch), .result_mon(result_ch),
    .contact_rdy(contact_ch.ready), .result_rdy(result_ch.ready),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  initial begin
    contact_ch.valid = 1'b0;
    contact_ch.data = '0;
    result_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: bursts of stall, none near the end
  initial begin
    int n;
    @(negedge clk);
    forever begin
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(negedge clk);
      if (!calm && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 17);
        result_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
    end
  end

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 131072) - 65536;
      4: return $urandom_range(0, 2097152) - 1048576;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] pick_mass();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 31'h7fffffff;
      2: return 31'($urandom_range(1, 4));
      3: return 31'($urandom_range(1, 262144));
      default: return 31'($urandom);
    endcase
  endfunction

  function automatic contact_t random_contact();
    contact_t c;
    c.normal_x = pick32(); c.normal_y = pick32(); c.normal_z = pick32();
    c.penetration_depth = pick32();
    c.vel_a_x = pick32(); c.vel_a_y = pick32(); c.vel_a_z = pick32();
    c.vel_b_x = pick32(); c.vel_b_y = pick32(); c.vel_b_z = pick32();
    c.inv_mass_a = pick_mass(); c.inv_mass_b = pick_mass();
    // in about half the contacts, unit-like normals so the impulse does not always saturate
    if ($urandom_range(0, 1)) begin
      c.normal_x = ($urandom_range(0, 131072) - 65536);
      c.normal_y = ($urandom_range(0, 131072) - 65536);
      c.normal_z = ($urandom_range(0, 131072) - 65536);
      c.vel_a_x = $urandom_range(0, 2000000) - 1000000;
      c.vel_b_z = $urandom_range(0, 2000000) - 1000000;
      c.penetration_depth = $urandom_range(0, 65536);
    end
    return c;
  endfunction

  task automatic send_contact(contact_t c);
    contact_ch.data <= c;
    contact_ch.valid <= 1'b1;
    @(posedge clk);
    while (!contact_ch.ready) @(posedge clk);
    sent++;
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      contact_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
  endtask

  task automatic drain();
    contact_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    contact_t c;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: extremes, zero masses, non-unit normal, saturation
    c = '0; c.inv_mass_a = 31'd65536; c.inv_mass_b = 31'd65536;
    c.normal_x = 32'sd65536; c.vel_b_x = -32'sd65536; c.penetration_depth = 32'sd6553;
    send_contact(c);
    c.inv_mass_a = '0; c.inv_mass_b = '0; c.vel_a_x = 32'sd12345;
    send_contact(c);
    c = '1; c.inv_mass_a = 31'h7fffffff; c.inv_mass_b = 31'h7fffffff;
    send_contact(c);
    c = '0; c.normal_x = 32'h7fffffff; c.normal_z = 32'h80000000;
    c.vel_a_x = 32'h80000000; c.vel_b_x = 32'h7fffffff; c.inv_mass_a = 31'd1;
    c.penetration_depth = 32'h7fffffff;
    send_contact(c);
    c.inv_mass_a = '0; c.inv_mass_b = 31'd1; c.penetration_depth = 32'h80000000;
    send_contact(c);
    c.normal_y = 32'h7fffffff; c.vel_a_y = 32'h80000000; c.vel_b_z = 32'h7fffffff;
    c.vel_b_y = 32'h7fffffff; c.vel_a_z = 32'h80000000;
    send_contact(c);
    for (int i = 0; i < 12; i++) send_contact(random_contact());
    drain();

    // sweep config settings including both extremes
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin write_reg(REG_FRAME_TIME, '0); write_reg(REG_INV_FRAME_TIME, '0); end
        1: begin write_reg(REG_FRAME_TIME, '1); write_reg(REG_INV_FRAME_TIME, '1); end
        2: begin write_reg(REG_FRAME_TIME, 31'd65536); write_reg(REG_INV_FRAME_TIME, 31'd65536); end
        3: begin
          write_reg(2'd3, 31'($urandom)); // unknown index, ignored
          write_reg(REG_FRAME_TIME, 31'($urandom));
          write_reg(REG_INV_FRAME_TIME, 31'($urandom));
        end
        4: begin write_reg(REG_FRAME_TIME, 31'd1092); write_reg(REG_INV_FRAME_TIME, 31'd3932160); end
        default: begin
          write_reg(REG_FRAME_TIME, 31'd2184); write_reg(REG_INV_FRAME_TIME, 31'd1966080);
          calm = 1;
        end
      endcase
      for (int i = 0; i < 180; i++) send_contact(random_contact());
      drain();
    end

    $display("Covered %0d contacts over six timing settings, zero-mass and saturating cases,",
             sent);
    $display("with stalls on both channels; %0d result words checked.", results_seen);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
